FILE: hdl/uart_line_buffer_with_echo_top_defines.svh
// Assertion macros for the serial line buffer with echo.
// Used by the top level; needs clock and reset in scope.
`ifndef UART_LINE_BUFFER_WITH_ECHO_TOP_DEFINES_SVH
`define UART_LINE_BUFFER_WITH_ECHO_TOP_DEFINES_SVH

// same-cycle implication
`define ULEB_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ULEB_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/uleb_pkg.sv
// Shared types, constants and helpers for the serial line buffer with echo.
// No dependencies.
package uleb_pkg;

   localparam int DEPTH  = 1024;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   localparam logic [7:0] BACKSPACE_RESET = 8'h08;

   typedef enum logic [2:0] {
      CMD_RX    = 3'd0,
      CMD_HOST  = 3'd1,
      CMD_READ  = 3'd2,
      CMD_CLEAR = 3'd3,
      CMD_DRAIN = 3'd4
   } cmd_type;

   typedef struct packed {
      logic       wr;
      logic       dec;
      logic       clr;
      logic [7:0] data;
   } line_op_type;

   typedef struct packed {
      logic       push;
      logic       pop;
      logic [7:0] data;
   } txq_op_type;

   function automatic logic [ADDR_W-1:0] next_ptr(input logic [ADDR_W-1:0] p);
      logic [ADDR_W-1:0] r;
      if (32'(p) == DEPTH - 1) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

endpackage

FILE: hdl/uleb_line.sv
// Line store: synchronous memory plus fill count; oldest byte at address 0.
// Depends on uleb_pkg.
module uleb_line import uleb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_stb,
   input  logic [9:0]        rd_index,
   input  line_op_type       op,
   output logic [7:0]        rd_data,
   output logic [CNT_W-1:0]  fill,
   output logic [CNT_W-1:0]  fill_next
);

   logic [7:0]       mem [DEPTH];
   logic [7:0]       rd_data_ff;
   logic [CNT_W-1:0] fill_ff;
   logic [CNT_W-1:0] fill_in;

   always_comb begin
      fill_in = fill_ff;
      if (op.clr) begin
         fill_in = '0;
      end else if (op.wr) begin
         fill_in = fill_ff + 1'b1;
      end else if (op.dec) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (op.wr) begin
         mem[fill_ff[ADDR_W-1:0]] <= op.data;
      end
      if (rd_stb) begin
         rd_data_ff <= mem[ADDR_W'(rd_index)];
      end
   end

   assign rd_data   = rd_data_ff;
   assign fill      = fill_ff;
   assign fill_next = fill_in;

endmodule

FILE: hdl/uleb_txq.sv
// Transmit ring: synchronous memory with head, tail and fill count.
// Depends on uleb_pkg.
module uleb_txq import uleb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_stb,
   input  txq_op_type        op,
   output logic [7:0]        rd_data,
   output logic [CNT_W-1:0]  fill,
   output logic [CNT_W-1:0]  fill_next
);

   logic [7:0]        mem [DEPTH];
   logic [7:0]        rd_data_ff;
   logic [ADDR_W-1:0] head_ff;
   logic [ADDR_W-1:0] head_in;
   logic [ADDR_W-1:0] tail_ff;
   logic [ADDR_W-1:0] tail_in;
   logic [CNT_W-1:0]  fill_ff;
   logic [CNT_W-1:0]  fill_in;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      fill_in = fill_ff;
      if (op.push) begin
         tail_in = next_ptr(tail_ff);
         fill_in = fill_ff + 1'b1;
      end else if (op.pop) begin
         head_in = next_ptr(head_ff);
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (op.push) begin
         mem[tail_ff] <= op.data;
      end
      if (rd_stb) begin
         rd_data_ff <= mem[head_ff];
      end
   end

   assign rd_data   = rd_data_ff;
   assign fill      = fill_ff;
   assign fill_next = fill_in;

endmodule

FILE: hdl/uart_line_buffer_with_echo_top.sv
// Serial line buffer with echo: line store, transmit ring, command sequencer.
// Each request is registered along with a read of the line and ring memories, then
// updated in the exec state; no new request is taken until that update is done.
// A full response register stalls the update stage until the beat is taken.
// Synchronous reset empties both stores and sets the backspace code to 0x08.
// Depends on uleb_pkg, uleb_line, uleb_txq and the defines header.
`include "uart_line_buffer_with_echo_top_defines.svh"

module uart_line_buffer_with_echo_top import uleb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_cmd,
   input  logic [7:0]  req_data_byte,
   input  logic [9:0]  req_read_index,
   input  logic        req_tx_hw_full,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_tx_valid,
   output logic [7:0]  rsp_tx_byte,
   output logic [7:0]  rsp_read_byte,
   output logic [10:0] rsp_line_count,
   output logic [10:0] rsp_queue_count,
   output logic        rsp_rx_event,
   output logic        rsp_line_overflow,
   output logic        rsp_tx_dropped
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type   state_ff, state_in;
   logic [7:0]  bs_ff;
   logic [2:0]  cmd_ff;
   logic [7:0]  data_ff;
   logic [9:0]  idx_ff;
   logic        hw_full_ff;

   logic        rsp_valid_ff;
   logic        tx_valid_ff;
   logic [7:0]  tx_byte_ff;
   logic [7:0]  read_byte_ff;
   logic [10:0] line_count_ff;
   logic [10:0] queue_count_ff;
   logic        rx_event_ff;
   logic        overflow_ff;
   logic        dropped_ff;

   logic              accept;
   logic              done;
   line_op_type       line_op;
   txq_op_type        txq_op;
   logic [7:0]        line_rd;
   logic [7:0]        txq_rd;
   logic [CNT_W-1:0]  line_fill;
   logic [CNT_W-1:0]  line_fill_nx;
   logic [CNT_W-1:0]  q_fill;
   logic [CNT_W-1:0]  q_fill_nx;

   logic        is_rx, is_send, is_bs, line_full, q_empty, q_full;
   logic        direct, drop, pop, overflow, rd_hit;
   logic [7:0]  tx_byte;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign done      = (state_ff == ST_EXEC) && (!rsp_valid_ff || !rsp_stall);

   uleb_line u_line (
      .clock     (clock),
      .reset     (reset),
      .rd_stb    (accept),
      .rd_index  (req_read_index),
      .op        (line_op),
      .rd_data   (line_rd),
      .fill      (line_fill),
      .fill_next (line_fill_nx)
   );

   uleb_txq u_txq (
      .clock     (clock),
      .reset     (reset),
      .rd_stb    (accept),
      .op        (txq_op),
      .rd_data   (txq_rd),
      .fill      (q_fill),
      .fill_next (q_fill_nx)
   );

   always_comb begin
      is_rx     = (cmd_ff == CMD_RX);
      is_send   = is_rx || (cmd_ff == CMD_HOST);
      is_bs     = (data_ff == bs_ff);
      line_full = (32'(line_fill) >= DEPTH);
      q_empty   = (q_fill == '0);
      q_full    = (32'(q_fill) >= DEPTH);
      direct    = is_send && q_empty && !hw_full_ff;
      drop      = is_send && !direct && q_full;
      pop       = (cmd_ff == CMD_DRAIN) && !q_empty;
      overflow  = is_rx && !is_bs && line_full;
      rd_hit    = (cmd_ff == CMD_READ) && (32'(idx_ff) < 32'(line_fill));

      line_op.wr   = done && is_rx && !is_bs && !line_full;
      line_op.dec  = done && is_rx && is_bs && (line_fill != '0);
      line_op.clr  = done && (cmd_ff == CMD_CLEAR);
      line_op.data = data_ff;

      txq_op.push = done && is_send && !direct && !q_full;
      txq_op.pop  = done && pop;
      txq_op.data = data_ff;

      tx_byte = 8'h00;
      if (direct) begin
         tx_byte = data_ff;
      end else if (pop) begin
         tx_byte = txq_rd;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bs_ff        <= BACKSPACE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            bs_ff <= csr_write_data;
         end
         if (done) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // hold the item and the result beat
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff     <= req_cmd;
         data_ff    <= req_data_byte;
         idx_ff     <= req_read_index;
         hw_full_ff <= req_tx_hw_full;
      end
      if (done) begin
         tx_valid_ff    <= direct || pop;
         tx_byte_ff     <= tx_byte;
         read_byte_ff   <= rd_hit ? line_rd : 8'h00;
         line_count_ff  <= 11'(line_fill_nx);
         queue_count_ff <= 11'(q_fill_nx);
         rx_event_ff    <= is_rx;
         overflow_ff    <= overflow;
         dropped_ff     <= drop;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_tx_valid      = tx_valid_ff;
   assign rsp_tx_byte       = tx_byte_ff;
   assign rsp_read_byte     = read_byte_ff;
   assign rsp_line_count    = line_count_ff;
   assign rsp_queue_count   = queue_count_ff;
   assign rsp_rx_event      = rx_event_ff;
   assign rsp_line_overflow = overflow_ff;
   assign rsp_tx_dropped    = dropped_ff;

   `ULEB_ASSERT_NEXT(a_accept_busy, req_valid && !req_stall, state_ff == ST_EXEC, "accept without exec")
   `ULEB_ASSERT_NOW(a_tx_xor_drop, rsp_valid_ff, !(tx_valid_ff && dropped_ff), "sent and dropped")
   `ULEB_ASSERT_NOW(a_line_bound, 1'b1, 32'(line_fill) <= DEPTH, "line fill beyond depth")
   `ULEB_ASSERT_NOW(a_push_pop, 1'b1, !(txq_op.push && txq_op.pop), "ring push and pop")

endmodule

FILE: dv/uart_line_buffer_with_echo_top_tb.sv
// Self-checking testbench for the serial line buffer with echo.
// Predicts every response beat from its own copy of the line store and transmit ring.
// Depends on uleb_pkg and uart_line_buffer_with_echo_top.
`timescale 1ns / 100ps

module uart_line_buffer_with_echo_top_tb import uleb_pkg::*;;

   localparam logic [2:0] CMD_SPARE_LO = 3'd5;
   localparam logic [2:0] CMD_SPARE_HI = 3'd7;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_OFF_CYCLES = 300;

   typedef struct packed {
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic [7:0]  read_byte;
      logic [10:0] line_count;
      logic [10:0] queue_count;
      logic        rx_event;
      logic        line_overflow;
      logic        tx_dropped;
   } echo_beat_type;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [7:0]  csr_write_data;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_cmd;
   logic [7:0]  req_data_byte;
   logic [9:0]  req_read_index;
   logic        req_tx_hw_full;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_tx_valid;
   logic [7:0]  rsp_tx_byte;
   logic [7:0]  rsp_read_byte;
   logic [10:0] rsp_line_count;
   logic [10:0] rsp_queue_count;
   logic        rsp_rx_event;
   logic        rsp_line_overflow;
   logic        rsp_tx_dropped;

   logic [7:0] line_mem [DEPTH];
   logic [7:0] ring_mem [DEPTH];
   int         line_wr_ptr;
   int         line_len;
   int         ring_rd_ptr;
   int         ring_wr_ptr;
   int         ring_len;
   logic [7:0] bs_code;

   echo_beat_type expected_beats [$];
   int            mismatches;
   bit            idle_enable;
   int            rsp_hold_cycles;

   uart_line_buffer_with_echo_top uut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_data_byte     (req_data_byte),
      .req_read_index    (req_read_index),
      .req_tx_hw_full    (req_tx_hw_full),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_tx_valid      (rsp_tx_valid),
      .rsp_tx_byte       (rsp_tx_byte),
      .rsp_read_byte     (rsp_read_byte),
      .rsp_line_count    (rsp_line_count),
      .rsp_queue_count   (rsp_queue_count),
      .rsp_rx_event      (rsp_rx_event),
      .rsp_line_overflow (rsp_line_overflow),
      .rsp_tx_dropped    (rsp_tx_dropped)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int wrap_inc(input int p);
      return (p + 1 >= DEPTH) ? 0 : p + 1;
   endfunction

   // echo straight out, enqueue, or drop
   function automatic void route_tx(input logic [7:0] b, input logic hw_full,
                                    inout echo_beat_type beat);
      if (ring_len == 0 && !hw_full) begin
         beat.tx_valid = 1'b1;
         beat.tx_byte  = b;
      end else if (ring_len < DEPTH) begin
         ring_mem[ring_wr_ptr] = b;
         ring_wr_ptr = wrap_inc(ring_wr_ptr);
         ring_len++;
      end else begin
         beat.tx_dropped = 1'b1;
      end
   endfunction

   function automatic echo_beat_type predict_echo(input logic [2:0] cmd, input logic [7:0] data,
                                                  input logic [9:0] idx, input logic hw_full);
      echo_beat_type beat;
      beat = '0;
      case (cmd)
         CMD_RX: begin
            beat.rx_event = 1'b1;
            if (data != bs_code) begin
               if (line_len < DEPTH) begin
                  line_mem[line_wr_ptr] = data;
                  line_wr_ptr = wrap_inc(line_wr_ptr);
                  line_len++;
               end else begin
                  beat.line_overflow = 1'b1;
               end
            end else if (line_len != 0) begin
               line_len--;
               line_wr_ptr = line_len;
            end
            route_tx(data, hw_full, beat);
         end
         CMD_HOST: begin
            route_tx(data, hw_full, beat);
         end
         CMD_READ: begin
            if (int'(idx) < line_len) beat.read_byte = line_mem[idx];
         end
         CMD_CLEAR: begin
            line_len = 0;
            line_wr_ptr = 0;
         end
         CMD_DRAIN: begin
            if (ring_len != 0) begin
               beat.tx_valid = 1'b1;
               beat.tx_byte  = ring_mem[ring_rd_ptr];
               ring_rd_ptr = wrap_inc(ring_rd_ptr);
               ring_len--;
            end
         end
         default: begin
         end
      endcase
      beat.line_count  = 11'(line_len);
      beat.queue_count = 11'(ring_len);
      return beat;
   endfunction

   function automatic void check_field(input string name, input logic [10:0] want,
                                       input logic [10:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   task automatic send_item(input logic [2:0] cmd, input logic [7:0] data,
                            input logic [9:0] idx, input logic hw_full);
      int gap;
      gap = idle_enable ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_cmd        <= cmd;
      req_data_byte  <= data;
      req_read_index <= idx;
      req_tx_hw_full <= hw_full;
      req_valid      <= 1'b1;
      do @(negedge clock); while (req_stall);
      @(posedge clock);
      expected_beats.push_back(predict_echo(cmd, data, idx, hw_full));
   endtask

   task automatic wait_for_quiet();
      req_valid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_backspace(input logic [7:0] code);
      wait_for_quiet();
      csr_write_enable <= 1'b1;
      csr_write_data   <= code;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      bs_code = code;
   endtask

   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      do b = 8'($urandom); while (b == bs_code);
      return b;
   endfunction

   task automatic test_each_command();
      send_item(CMD_RX, 8'h00, 10'($urandom), 1'b0);
      send_item(CMD_RX, 8'hFF, 10'($urandom), 1'b0);
      send_item(CMD_READ, 8'($urandom), 10'd0, 1'b0);
      send_item(CMD_READ, 8'($urandom), 10'd1, 1'b1);
      send_item(CMD_READ, 8'($urandom), 10'd2, 1'b0);
      send_item(CMD_READ, 8'($urandom), 10'h3FF, 1'b0);
      send_item(CMD_RX, bs_code, 10'($urandom), 1'b0);
      send_item(CMD_HOST, 8'hA5, 10'($urandom), 1'b1);
      send_item(CMD_HOST, 8'h5A, 10'($urandom), 1'b0);
      send_item(CMD_RX, 8'h3C, 10'($urandom), 1'b0);
      send_item(CMD_DRAIN, 8'($urandom), 10'($urandom), 1'b1);
      send_item(CMD_DRAIN, 8'($urandom), 10'($urandom), 1'b0);
      send_item(CMD_DRAIN, 8'($urandom), 10'($urandom), 1'b0);
      send_item(CMD_DRAIN, 8'($urandom), 10'($urandom), 1'b1);
      send_item(CMD_CLEAR, 8'($urandom), 10'($urandom), 1'b0);
      send_item(CMD_RX, bs_code, 10'($urandom), 1'b1);
      send_item(CMD_READ, 8'($urandom), 10'd0, 1'b0);
      for (int c = int'(CMD_SPARE_LO); c <= int'(CMD_SPARE_HI); c++) begin
         send_item(3'(c), 8'hFF, 10'h3FF, 1'b1);
      end
   endtask

   task automatic test_backspace_extremes();
      write_backspace(8'h00);
      send_item(CMD_RX, 8'h08, 10'($urandom), 1'b0);
      send_item(CMD_RX, 8'h00, 10'($urandom), 1'b0);
      send_item(CMD_RX, 8'h00, 10'($urandom), 1'b0);
      write_backspace(8'hFF);
      send_item(CMD_RX, 8'h00, 10'($urandom), 1'b0);
      send_item(CMD_RX, 8'h7E, 10'($urandom), 1'b1);
      send_item(CMD_RX, 8'hFF, 10'($urandom), 1'b0);
      send_item(CMD_READ, 8'($urandom), 10'd0, 1'b0);
      send_item(CMD_RX, 8'hFF, 10'($urandom), 1'b0);
      send_item(CMD_RX, 8'hFF, 10'($urandom), 1'b0);
   endtask

   // fill line store and ring past capacity, then read back and empty the ring
   task automatic test_full_stores();
      write_backspace(8'($urandom));
      send_item(CMD_CLEAR, 8'($urandom), 10'($urandom), 1'b0);
      for (int i = 0; i < DEPTH + 6; i++) begin
         send_item(CMD_RX, plain_byte(), 10'($urandom), (i == 0) ? 1'b1 : 1'($urandom));
      end
      send_item(CMD_READ, 8'($urandom), 10'd0, 1'b0);
      send_item(CMD_READ, 8'($urandom), 10'h3FF, 1'b0);
      send_item(CMD_READ, 8'($urandom), 10'h200, 1'b0);
      send_item(CMD_RX, bs_code, 10'($urandom), 1'b0);
      send_item(CMD_READ, 8'($urandom), 10'h3FF, 1'b0);
      send_item(CMD_RX, plain_byte(), 10'($urandom), 1'b0);
      send_item(CMD_READ, 8'($urandom), 10'h3FF, 1'b0);
      send_item(CMD_RX, plain_byte(), 10'($urandom), 1'b0);
      send_item(CMD_HOST, 8'($urandom), 10'($urandom), 1'b0);
      for (int i = 0; i < DEPTH + 4; i++) begin
         send_item(CMD_DRAIN, 8'($urandom), 10'($urandom), 1'($urandom));
      end
      send_item(CMD_CLEAR, 8'($urandom), 10'($urandom), 1'b0);
      send_item(CMD_READ, 8'($urandom), 10'd0, 1'b0);
   endtask

   task automatic test_backpressure();
      wait_for_quiet();
      idle_enable = 1'b0;
      rsp_hold_cycles = HOLD_OFF_CYCLES;
      for (int i = 0; i < 80; i++) begin
         send_item(3'($urandom_range(CMD_RX, CMD_DRAIN)), 8'($urandom), 10'($urandom),
                   1'($urandom));
      end
      wait_for_quiet();
      idle_enable = 1'b1;
   endtask

   task automatic test_random_traffic();
      int sel;
      logic [2:0] cmd;
      logic [7:0] data;
      logic [9:0] idx;
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0:       write_backspace(8'h00);
            1:       write_backspace(8'hFF);
            2:       write_backspace(BACKSPACE_RESET);
            default: write_backspace(8'($urandom));
         endcase
         for (int i = 0; i < 40; i++) begin
            if ($urandom_range(0, 39) == 0) idle_enable = ~idle_enable;
            sel = $urandom_range(0, 99);
            if (sel < 25)      cmd = CMD_RX;
            else if (sel < 35) cmd = CMD_HOST;
            else if (sel < 50) cmd = CMD_READ;
            else if (sel < 54) cmd = CMD_CLEAR;
            else if (sel < 94) cmd = CMD_DRAIN;
            else               cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
            data = ($urandom_range(0, 4) == 0) ? bs_code : 8'($urandom);
            if (line_len > 0 && $urandom_range(0, 4) != 0)
               idx = 10'($urandom_range(0, line_len - 1));
            else
               idx = 10'($urandom);
            send_item(cmd, data, idx, ($urandom_range(0, 3) == 0));
         end
      end
      idle_enable = 1'b1;
   endtask

   initial begin
      int gap;
      rsp_stall <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end
         gap = idle_enable ? $urandom_range(0, 14) : 0;
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(negedge clock); while (!rsp_valid);
         @(posedge clock);
      end
   end

   initial begin
      echo_beat_type want;
      forever begin
         @(negedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (expected_beats.size() == 0) begin
               $display("%0t: response beat with nothing expected, expected none, actual tx %0d",
                        $time, rsp_tx_byte);
               mismatches++;
            end else begin
               want = expected_beats.pop_front();
               check_field("tx_valid", 11'(want.tx_valid), 11'(rsp_tx_valid));
               check_field("tx_byte", 11'(want.tx_byte), 11'(rsp_tx_byte));
               check_field("read_byte", 11'(want.read_byte), 11'(rsp_read_byte));
               check_field("line_count", want.line_count, rsp_line_count);
               check_field("queue_count", want.queue_count, rsp_queue_count);
               check_field("rx_event", 11'(want.rx_event), 11'(rsp_rx_event));
               check_field("line_overflow", 11'(want.line_overflow), 11'(rsp_line_overflow));
               check_field("tx_dropped", 11'(want.tx_dropped), 11'(rsp_tx_dropped));
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      req_valid        <= 1'b0;
      req_cmd          <= '0;
      req_data_byte    <= '0;
      req_read_index   <= '0;
      req_tx_hw_full   <= 1'b0;
      line_wr_ptr      = 0;
      line_len         = 0;
      ring_rd_ptr      = 0;
      ring_wr_ptr      = 0;
      ring_len         = 0;
      bs_code          = BACKSPACE_RESET;
      mismatches       = 0;
      idle_enable      = 1'b1;
      rsp_hold_cycles  = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_each_command();
      test_backspace_extremes();
      test_full_stores();
      test_backpressure();
      test_random_traffic();
      wait_for_quiet();

      if (mismatches == 0 && expected_beats.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
